// ===== design/rzt_pkg.sv =====
package rzt_pkg;

  // Operation codes carried in the input tuser
  localparam logic [2:0] OP_DEFINE  = 3'd0;
  localparam logic [2:0] OP_HANDLER = 3'd1;
  localparam logic [2:0] OP_COUNT   = 3'd2;
  localparam logic [2:0] OP_TILE    = 3'd3;
  localparam logic [2:0] OP_BOX     = 3'd4;

  // Result kinds carried in the output tuser
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ENTER  = 2'd1;
  localparam logic [1:0] KIND_LEAVE  = 2'd2;

  // Handler flag bits
  localparam int FLAG_ENTER = 0;
  localparam int FLAG_LEAVE = 1;

  // Classified command passed from the front end to the executor
  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic        in_range;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [7:0]  handler_flags;
    logic [7:0]  handler_bank;
    logic [15:0] handler_address;
    logic        force_req;
    logic [7:0]  box_l;
    logic [7:0]  box_t;
    logic [7:0]  box_r;
    logic [7:0]  box_b;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  zone_index;
    logic        zone_hit;
    logic [7:0]  event_bank;
    logic [15:0] event_address;
    logic        activated;
    logic        last_of_run;
  } res_t;

endpackage

// ===== design/rzt_ram.sv =====
module rzt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rzt_front.sv =====
module rzt_front #(
  parameter int ZONES          = 32,
  parameter int SUBPIXEL_SHIFT = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [119:0]  s_tdata,
  input  logic [2:0]    s_tuser,
  output logic          q_valid,
  input  logic          q_ready,
  output rzt_pkg::cmd_t q_cmd
);

  rzt_pkg::cmd_t cmd;
  rzt_pkg::cmd_t fifo [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  // Tile edge of a box: bits 3..10 of the shifted offset plus sign-extended pixel edge
  function automatic logic [7:0] box_tile(input logic [15:0] off, input logic [7:0] e);
    logic [15:0] sum;
    sum = (off >> SUBPIXEL_SHIFT) + {{8{e[7]}}, e};
    return sum[10:3];
  endfunction

  // Classify the incoming word
  always_comb begin
    cmd.op              = s_tuser;
    cmd.slot            = s_tdata[5:0];
    cmd.in_range        = {1'b0, s_tdata[5:0]} < 7'(ZONES);
    cmd.px              = s_tdata[13:6];
    cmd.py              = s_tdata[29:22];
    cmd.rect_width      = s_tdata[45:38];
    cmd.rect_height     = s_tdata[53:46];
    cmd.handler_flags   = s_tdata[61:54];
    cmd.handler_bank    = s_tdata[69:62];
    cmd.handler_address = s_tdata[85:70];
    cmd.force_req       = s_tdata[86];
    cmd.box_l           = box_tile(s_tdata[21:6], s_tdata[94:87]);
    cmd.box_r           = box_tile(s_tdata[21:6], s_tdata[102:95]);
    cmd.box_t           = box_tile(s_tdata[37:22], s_tdata[110:103]);
    cmd.box_b           = box_tile(s_tdata[37:22], s_tdata[118:111]);
  end

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = fifo[rptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/rzt_back.sv =====
module rzt_back #(
  parameter int ZONES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  rzt_pkg::cmd_t q_cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output rzt_pkg::res_t res
);

  localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int CW = $clog2(ZONES + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CRD  = 10'b0000000010,
    S_HCLR = 10'b0000000100,
    S_SCAN = 10'b0000001000,
    S_DEC  = 10'b0000010000,
    S_LRD  = 10'b0000100000,
    S_LCHK = 10'b0001000000,
    S_ERD  = 10'b0010000000,
    S_ECHK = 10'b0100000000,
    S_STAT = 10'b1000000000
  } state_t;

  state_t        state;
  state_t        state_next;
  rzt_pkg::cmd_t cur;
  logic [CW-1:0] active_count;
  logic [7:0]    prev_tx;
  logic [7:0]    prev_ty;
  logic          pv;
  logic [IW-1:0] pz;
  logic [IW-1:0] old_pz;
  logic          found;
  logic [IW-1:0] hit;
  logic          act;
  logic [CW-1:0] scan_idx;
  logic          chk_v;
  logic [IW-1:0] chk_idx;
  logic          rect_valid [ZONES];
  logic          hdl_valid [ZONES];
  logic          out_valid;
  rzt_pkg::res_t out_res;

  logic          r_we;
  logic [IW-1:0] r_waddr;
  logic [31:0]   r_wdata;
  logic [31:0]   r_rdata;
  logic          h_we;
  logic [IW-1:0] h_waddr;
  logic [31:0]   h_wdata;
  logic [IW-1:0] h_raddr;
  logic [31:0]   h_rdata;

  logic          pop;
  logic [CW-1:0] new_count;
  logic [31:0]   rect_e;
  logic [31:0]   hv;
  logic [7:0]    e_l, e_t, e_r, e_b;
  logic          tile_m, box_m, match;
  logic          issue_ok;
  logic          same;
  logic          out_free;
  logic          ld;
  rzt_pkg::res_t ld_res;

  function automatic logic [4:0] to_idx(input logic [IW-1:0] i);
    logic [6:0] x;
    x = 7'(i);
    return x[4:0];
  endfunction

  rzt_ram #(.WIDTH(32), .DEPTH(ZONES)) u_rect (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(IW'(scan_idx)), .rdata(r_rdata)
  );

  rzt_ram #(.WIDTH(32), .DEPTH(ZONES)) u_hdl (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign q_ready   = (state == S_IDLE);
  assign pop       = q_valid && q_ready;
  assign out_free  = !out_valid || res_ready;
  assign res_valid = out_valid;
  assign res       = out_res;
  assign issue_ok  = scan_idx < active_count;
  assign new_count = ({1'b0, q_cmd.slot} > 7'(ZONES)) ? CW'(ZONES) : CW'(q_cmd.slot);

  // Entry edges with 8-bit wrap; invalid entries read as zero
  assign rect_e = rect_valid[chk_idx] ? r_rdata : 32'd0;
  assign e_l    = rect_e[7:0];
  assign e_t    = rect_e[15:8];
  assign e_r    = e_l + rect_e[23:16] - 8'd1;
  assign e_b    = e_t + rect_e[31:24] - 8'd1;
  assign tile_m = ({1'b0, cur.px} + 9'd1 >= {1'b0, e_l}) && (cur.px <= e_r) &&
                  (cur.py >= e_t) && (cur.py <= e_b);
  assign box_m  = (cur.box_l <= e_r) && (cur.box_r >= e_l) &&
                  (cur.box_t <= e_b) && (cur.box_b >= e_t);
  assign match  = (cur.op == rzt_pkg::OP_TILE) ? tile_m : box_m;
  assign same   = (found == pv) && (!found || hit == pz);

  // Handler read address and masked handler word
  always_comb begin
    if (state == S_CRD || state == S_HCLR) begin
      h_raddr = IW'(cur.slot);
    end else if (state == S_LRD || state == S_LCHK) begin
      h_raddr = old_pz;
    end else begin
      h_raddr = hit;
    end
  end
  assign hv = hdl_valid[h_raddr] ? h_rdata : 32'd0;

  // Store writes
  always_comb begin
    r_we    = 1'b0;
    r_waddr = IW'(q_cmd.slot);
    r_wdata = {q_cmd.rect_height, q_cmd.rect_width, q_cmd.py, q_cmd.px};
    h_we    = 1'b0;
    h_waddr = IW'(q_cmd.slot);
    h_wdata = {q_cmd.handler_address, q_cmd.handler_bank, q_cmd.handler_flags};
    if (pop && q_cmd.in_range) begin
      if (q_cmd.op == rzt_pkg::OP_DEFINE) r_we = 1'b1;
      if (q_cmd.op == rzt_pkg::OP_HANDLER && q_cmd.handler_bank != 8'd0) h_we = 1'b1;
    end
    if (state == S_HCLR) begin
      h_we    = 1'b1;
      h_waddr = IW'(cur.slot);
      h_wdata = {24'd0, hv[7:0] & ~cur.handler_flags};
    end
  end

  // Result selection and next state
  always_comb begin
    state_next = state;
    ld         = 1'b0;
    ld_res     = '0;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          priority case (q_cmd.op)
            rzt_pkg::OP_HANDLER:
              state_next = (q_cmd.in_range && q_cmd.handler_bank == 8'd0) ? S_CRD : S_STAT;
            rzt_pkg::OP_TILE:
              state_next = (!q_cmd.force_req && q_cmd.px == prev_tx && q_cmd.py == prev_ty)
                           ? S_STAT : S_SCAN;
            rzt_pkg::OP_BOX: state_next = S_SCAN;
            default:         state_next = S_STAT;
          endcase
        end
      end
      S_CRD:  state_next = S_HCLR;
      S_HCLR: state_next = S_STAT;
      S_SCAN: begin
        if ((chk_v && match) || (!chk_v && !issue_ok)) state_next = S_DEC;
      end
      S_DEC: begin
        if (cur.op == rzt_pkg::OP_TILE) begin
          state_next = found ? S_ERD : S_STAT;
        end else if (!cur.force_req && same) begin
          state_next = S_STAT;
        end else if (pv && !same) begin
          state_next = S_LRD;
        end else begin
          state_next = found ? S_ERD : S_STAT;
        end
      end
      S_LRD: state_next = S_LCHK;
      S_LCHK: begin
        ld_res.kind          = rzt_pkg::KIND_LEAVE;
        ld_res.zone_index    = to_idx(old_pz);
        ld_res.event_bank    = hv[15:8];
        ld_res.event_address = hv[31:16];
        if (!hv[rzt_pkg::FLAG_LEAVE] || out_free) begin
          ld         = hv[rzt_pkg::FLAG_LEAVE];
          state_next = found ? S_ERD : S_STAT;
        end
      end
      S_ERD: state_next = S_ECHK;
      S_ECHK: begin
        ld_res.kind          = rzt_pkg::KIND_ENTER;
        ld_res.zone_index    = to_idx(hit);
        ld_res.event_bank    = hv[15:8];
        ld_res.event_address = hv[31:16];
        if (!hv[rzt_pkg::FLAG_ENTER] || out_free) begin
          ld         = hv[rzt_pkg::FLAG_ENTER];
          state_next = S_STAT;
        end
      end
      S_STAT: begin
        ld_res.kind        = rzt_pkg::KIND_STATUS;
        ld_res.zone_index  = found ? to_idx(hit) : 5'd0;
        ld_res.zone_hit    = found;
        ld_res.activated   = act;
        ld_res.last_of_run = 1'b1;
        if (out_free) begin
          ld         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ld) out_res <= ld_res;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Executor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_count <= '0;
      prev_tx      <= 8'd0;
      prev_ty      <= 8'd0;
      pv           <= 1'b0;
      pz           <= '0;
      old_pz       <= '0;
      found        <= 1'b0;
      hit          <= '0;
      act          <= 1'b0;
      scan_idx     <= '0;
      chk_v        <= 1'b0;
      chk_idx      <= '0;
      for (int i = 0; i < ZONES; i++) begin
        rect_valid[i] <= 1'b0;
        hdl_valid[i]  <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (r_we) rect_valid[r_waddr] <= 1'b1;
      if (h_we) hdl_valid[h_waddr]  <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur      <= q_cmd;
            found    <= 1'b0;
            act      <= 1'b0;
            hit      <= '0;
            scan_idx <= '0;
            chk_v    <= 1'b0;
            if (q_cmd.op == rzt_pkg::OP_COUNT) begin
              active_count <= new_count;
              for (int i = 0; i < ZONES; i++) begin
                if (CW'(i) >= new_count) begin
                  rect_valid[i] <= 1'b0;
                  hdl_valid[i]  <= 1'b0;
                end
              end
            end
            if (state_next == S_SCAN && q_cmd.op == rzt_pkg::OP_TILE) begin
              prev_tx <= q_cmd.px;
              prev_ty <= q_cmd.py;
            end
          end
        end
        S_SCAN: begin
          if (chk_v && match) begin
            found <= 1'b1;
            hit   <= chk_idx;
            chk_v <= 1'b0;
          end else if (issue_ok) begin
            chk_v    <= 1'b1;
            chk_idx  <= IW'(scan_idx);
            scan_idx <= scan_idx + CW'(1);
          end else begin
            chk_v <= 1'b0;
          end
        end
        S_DEC: begin
          if (cur.op == rzt_pkg::OP_TILE) begin
            act <= found;
          end else if (cur.force_req || !same) begin
            pv     <= found;
            pz     <= found ? hit : '0;
            old_pz <= pz;
          end
        end
        S_LCHK, S_ECHK: begin
          if (ld) act <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Only the status closes a run
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.last_of_run |-> out_res.kind == rzt_pkg::KIND_STATUS)
    else $error("last_of_run on a non-status result");

  // Events carry no hit or activation flags
  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind != rzt_pkg::KIND_STATUS |->
      !out_res.zone_hit && !out_res.activated && !out_res.last_of_run)
    else $error("event result with status fields set");

  // Active count never exceeds the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    active_count <= CW'(ZONES))
    else $error("active count above table depth");

  // No previous zone means index zero
  a_prev_none: assert property (@(posedge clk) disable iff (rst)
    !pv |-> pz == '0)
    else $error("stale previous zone index");

  // Scan never checks beyond the active entries
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    chk_v |-> CW'(chk_idx) < active_count)
    else $error("scan checked an inactive entry");

endmodule

// ===== design/rect_zone_table_enter_leave.sv =====
// Rectangle zone table with enter and leave events.
//
// Input words arrive on s_tvalid/s_tready; s_tuser carries the operation and
// s_tdata the operands. Each accepted word produces zero to two event words
// followed by one status word on m_tvalid/m_tready; m_tlast marks the status
// and m_tuser its kind (status, enter, leave).
// A two-entry command queue sits between the input front end and the
// executor, so words are taken while the executor scans or a result waits.
// Define, handler set and count go straight to the status word; a handler
// clear first reads the handler word and writes it back masked. A probe
// scans the active entries one per cycle through the rectangle memory port,
// stops at the first match, and reads the handler word for each event it
// needs before the status word.
// At most one word is executed at a time.
// Reset empties the queue, marks every table entry as zero through per-entry
// valid bits, zeroes the active count and previous tile, forgets the previous
// zone and needs no clearing pass. With m_tready low the executor holds its
// result and stalls before the next; the input side keeps filling the queue.
module rect_zone_table_enter_leave #(
  parameter int ZONES          = 32,
  parameter int SUBPIXEL_SHIFT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[5:0] coord_x[21:6] coord_y[37:22] rect_width[45:38] rect_height[53:46]
  // handler_flags[61:54] handler_bank[69:62] handler_address[85:70]
  // force_req[86] box_x_edges[102:87] box_y_edges[118:103], zero fill above
  input  logic [119:0] s_tdata,
  // op[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // zone_index[4:0] zone_hit[5] event_bank[13:6] event_address[29:14]
  // activated[30], zero fill above
  output logic [31:0]  m_tdata,
  // kind[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  logic          q_valid;
  logic          q_ready;
  rzt_pkg::cmd_t q_cmd;
  rzt_pkg::res_t res;

  rzt_front #(.ZONES(ZONES), .SUBPIXEL_SHIFT(SUBPIXEL_SHIFT)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rzt_back #(.ZONES(ZONES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  // Pack the result word
  assign m_tdata = {1'b0, res.activated, res.event_address, res.event_bank,
                    res.zone_hit, res.zone_index};
  assign m_tuser = res.kind;
  assign m_tlast = res.last_of_run;

endmodule

// ===== test/rect_zone_table_enter_leave_test.sv =====
`timescale 1ns / 1ps

module rect_zone_table_enter_leave_test;

  localparam int NZ = 32;
  localparam int SUB_SHIFT = 4;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  flags;
    logic [7:0]  bank;
    logic [15:0] addr;
    logic        force_req;
    logic [15:0] bx;
    logic [15:0] by;
  } zone_cmd_t;

  // Shadow of the zone table; works out the words each command should produce
  class zone_scoreboard;
    logic [31:0] rects [NZ];
    logic [31:0] handlers [NZ];
    int unsigned count;
    logic [7:0]  last_tx, last_ty;
    bit          zone_valid;
    logic [4:0]  zone_idx;
    rzt_pkg::res_t pending [$];
    int          errors;
    int          n_enter, n_leave, n_hits, n_words;

    function new();
      foreach (rects[i]) begin
        rects[i] = '0;
        handlers[i] = '0;
      end
      count = 0; last_tx = 0; last_ty = 0; zone_valid = 0; zone_idx = 0;
      errors = 0; n_enter = 0; n_leave = 0; n_hits = 0; n_words = 0;
    endfunction

    function void push_event(logic [1:0] k, logic [4:0] idx);
      rzt_pkg::res_t r;
      r = '0;
      r.kind = k;
      r.zone_index = idx;
      r.event_bank = handlers[idx][15:8];
      r.event_address = handlers[idx][31:16];
      pending.push_back(r);
      if (k == rzt_pkg::KIND_ENTER) n_enter++; else n_leave++;
    endfunction

    function void edges(int i, output logic [7:0] l, t, r, b);
      l = rects[i][7:0];
      t = rects[i][15:8];
      r = l + rects[i][23:16] - 8'd1;
      b = t + rects[i][31:24] - 8'd1;
    endfunction

    function logic [7:0] tile_of(logic [15:0] off, logic [7:0] e);
      logic [15:0] s;
      s = (off >> SUB_SHIFT) + {{8{e[7]}}, e};
      return s[10:3];
    endfunction

    // Note an accepted command and queue its expected words
    function void note_cmd(zone_cmd_t c);
      logic [7:0] l, t, r, b, bl, bt, br, bb;
      bit found, same;
      logic [4:0] hit;
      bit act;
      rzt_pkg::res_t st;
      found = 0; hit = 0; act = 0;
      n_words++;
      case (c.op)
        rzt_pkg::OP_DEFINE:
          if (c.slot < NZ) rects[c.slot] = {c.h, c.w, c.cy[7:0], c.cx[7:0]};
        rzt_pkg::OP_HANDLER: if (c.slot < NZ) begin
          if (c.bank != 0) handlers[c.slot] = {c.addr, c.bank, c.flags};
          else handlers[c.slot] = {24'd0, handlers[c.slot][7:0] & ~c.flags};
        end
        rzt_pkg::OP_COUNT: begin
          count = (c.slot > NZ) ? NZ : c.slot;
          for (int i = int'(count); i < NZ; i++) begin
            rects[i] = '0;
            handlers[i] = '0;
          end
        end
        rzt_pkg::OP_TILE: begin
          if (c.force_req || c.cx[7:0] != last_tx || c.cy[7:0] != last_ty) begin
            for (int i = 0; i < count && !found; i++) begin
              edges(i, l, t, r, b);
              if ({1'b0, c.cx[7:0]} + 9'd1 >= {1'b0, l} && c.cx[7:0] <= r &&
                  c.cy[7:0] >= t && c.cy[7:0] <= b) begin
                found = 1; hit = 5'(i);
              end
            end
            last_tx = c.cx[7:0];
            last_ty = c.cy[7:0];
            if (found) begin
              if (handlers[hit][rzt_pkg::FLAG_ENTER]) push_event(rzt_pkg::KIND_ENTER, hit);
              act = 1;
            end
          end
        end
        rzt_pkg::OP_BOX: begin
          bl = tile_of(c.cx, c.bx[7:0]);
          br = tile_of(c.cx, c.bx[15:8]);
          bt = tile_of(c.cy, c.by[7:0]);
          bb = tile_of(c.cy, c.by[15:8]);
          for (int i = 0; i < count && !found; i++) begin
            edges(i, l, t, r, b);
            if (bl <= r && br >= l && bt <= b && bb >= t) begin
              found = 1; hit = 5'(i);
            end
          end
          same = (found == zone_valid) && (!found || hit == zone_idx);
          if (c.force_req || !same) begin
            if (zone_valid && !same) begin
              if (handlers[zone_idx][rzt_pkg::FLAG_LEAVE]) begin
                push_event(rzt_pkg::KIND_LEAVE, zone_idx); act = 1;
              end
            end
            if (found && handlers[hit][rzt_pkg::FLAG_ENTER]) begin
              push_event(rzt_pkg::KIND_ENTER, hit); act = 1;
            end
            zone_valid = found;
            zone_idx = found ? hit : 5'd0;
          end
        end
        default: ;
      endcase
      if (found) n_hits++;
      st = '0;
      st.kind = rzt_pkg::KIND_STATUS;
      st.zone_index = found ? hit : 5'd0;
      st.zone_hit = found;
      st.activated = act;
      st.last_of_run = 1;
      pending.push_back(st);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(rzt_pkg::res_t got);
      rzt_pkg::res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word kind=%0d", got.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
      end
      if (got.zone_index != e.zone_index) begin
        $error("zone_index: expected %0d, got %0d", e.zone_index, got.zone_index); errors++;
      end
      if (got.zone_hit != e.zone_hit) begin
        $error("zone_hit: expected %0d, got %0d", e.zone_hit, got.zone_hit); errors++;
      end
      if (got.event_bank != e.event_bank) begin
        $error("event_bank: expected %0h, got %0h", e.event_bank, got.event_bank); errors++;
      end
      if (got.event_address != e.event_address) begin
        $error("event_address: expected %0h, got %0h", e.event_address, got.event_address);
        errors++;
      end
      if (got.activated != e.activated) begin
        $error("activated: expected %0d, got %0d", e.activated, got.activated); errors++;
      end
      if (got.last_of_run != e.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", e.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [31:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  zone_scoreboard board;
  bit  sending_done = 0;
  bit  calm = 0;
  bit  long_hold = 0;
  int  idle_cycles = 0;

  rect_zone_table_enter_leave DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // Drive one word and hold it until taken
  task automatic send_cmd(zone_cmd_t c);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= c.op;
    s_tdata  <= {1'b0, c.by, c.bx, c.force_req, c.addr, c.bank, c.flags,
                 c.h, c.w, c.cy, c.cx, c.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_cmd(c);
  endtask

  function automatic zone_cmd_t blank_cmd(logic [2:0] op);
    zone_cmd_t c;
    c.op = op; c.slot = 0; c.cx = 0; c.cy = 0; c.w = 0; c.h = 0; c.flags = 0;
    c.bank = 0; c.addr = 0; c.force_req = 0; c.bx = 0; c.by = 0;
    return c;
  endfunction

  function automatic zone_cmd_t rand_cmd();
    zone_cmd_t c;
    int p;
    c.slot = $urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    c.cx = 16'($urandom); c.cy = 16'($urandom);
    c.w = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(1, 12));
    c.h = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(1, 12));
    c.flags = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.bank = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom);
    c.addr = 16'($urandom);
    c.force_req = 1'($urandom_range(0, 1));
    c.bx = 16'($urandom); c.by = 16'($urandom);
    p = $urandom_range(0, 99);
    if (p < 12) c.op = rzt_pkg::OP_DEFINE;
    else if (p < 24) c.op = rzt_pkg::OP_HANDLER;
    else if (p < 30) c.op = rzt_pkg::OP_COUNT;
    else if (p < 60) c.op = rzt_pkg::OP_TILE;
    else if (p < 97) c.op = rzt_pkg::OP_BOX;
    else c.op = 3'($urandom_range(5, 7));
    // keep probes near the small table so they hit often
    if (c.op == rzt_pkg::OP_TILE && $urandom_range(0, 3) != 0) begin
      c.cx[7:0] = 8'($urandom_range(0, 24)); c.cy[7:0] = 8'($urandom_range(0, 24));
    end
    if (c.op == rzt_pkg::OP_BOX && $urandom_range(0, 3) != 0) begin
      c.cx = 16'($urandom_range(0, 2047)); c.cy = 16'($urandom_range(0, 2047));
      c.bx = {8'($urandom_range(0, 40)), 8'($urandom_range(0, 255))};
      c.by = {8'($urandom_range(0, 40)), 8'($urandom_range(0, 255))};
    end
    if (c.op == rzt_pkg::OP_COUNT && $urandom_range(0, 2) != 0)
      c.slot = 6'($urandom_range(4, 10));
    return c;
  endfunction

  // Directed opening, then random words
  initial begin : stimulus
    zone_cmd_t c;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    c = blank_cmd(rzt_pkg::OP_COUNT); c.slot = 63; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_DEFINE); c.slot = 0; c.cx = 16'hFF02; c.cy = 16'hFF03;
    c.w = 4; c.h = 4; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_DEFINE); c.slot = 1; c.cx = 16'h00FE; c.cy = 16'h00FE;
    c.w = 8'hFF; c.h = 8'hFF; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_DEFINE); c.slot = 40; c.cx = 16'hFFFF; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_HANDLER); c.slot = 0; c.flags = 8'hFF; c.bank = 8'hFF;
    c.addr = 16'hFFFF; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_HANDLER); c.slot = 1; c.flags = 8'h03; c.bank = 8'h01;
    c.addr = 16'h1234; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_HANDLER); c.slot = 63; c.bank = 8'h05; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_TILE); c.cx = 3; c.cy = 4; send_cmd(c);
    send_cmd(c);
    c.force_req = 1; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_TILE); c.cx = 16'hFFFF; c.cy = 16'hFFFF; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_BOX); c.cx = 16'h0100; c.cy = 16'h0100; c.bx = 16'h0800;
    c.by = 16'h0800; send_cmd(c);
    send_cmd(c);
    c.force_req = 1; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_BOX); c.cx = 16'hFFFF; c.cy = 16'hFFFF; c.bx = 16'h7F80;
    c.by = 16'h807F; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_HANDLER); c.slot = 0; c.flags = 8'h01; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_BOX); c.cx = 16'h0100; c.cy = 16'h0100; c.bx = 16'h0800;
    c.by = 16'h0800; send_cmd(c);
    c = blank_cmd(3'd5); send_cmd(c);
    c = blank_cmd(3'd7); c.cx = 16'hFFFF; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_COUNT); c.slot = 0; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_TILE); c.cx = 9; c.force_req = 1; send_cmd(c);
    c = blank_cmd(rzt_pkg::OP_COUNT); c.slot = 6; send_cmd(c);
    for (int n = 0; n < 390; n++) begin
      if (n == 330) calm = 1;
      if (n == 60) long_hold = 1;
      send_cmd(rand_cmd());
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  // Receiver with bursts of back-pressure and one long hold-off
  initial begin : receiver
    int burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        m_tready <= 0;
        repeat (300) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        m_tready <= 0;
        repeat (burst) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rzt_pkg::res_t r;
      r.kind = m_tuser;
      r.zone_index = m_tdata[4:0];
      r.zone_hit = m_tdata[5];
      r.event_bank = m_tdata[13:6];
      r.event_address = m_tdata[29:14];
      r.activated = m_tdata[30];
      r.last_of_run = m_tlast;
      board.check_word(r);
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : finish_run
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d words: %0d hits, %0d enter and %0d leave events.",
             board.n_words, board.n_hits, board.n_enter, board.n_leave);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
